### hw/rtl/hrocs_pkg.sv
// Shared constants and types for the Hamming radius one center search block.
package hrocs_pkg;

  // Storage limits
  localparam int MAX_STRINGS = 16;
  localparam int MAX_LENGTH  = 16;
  localparam int STORE_DEPTH = MAX_STRINGS * MAX_LENGTH;

  // Letter alphabet: codes 0 (a) to 25 (z)
  localparam int LETTER_COUNT = 26;
  localparam int LETTER_W     = 5;
  localparam int CFG_W        = 5;

  // Derived widths
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TOT_W  = $clog2(STORE_DEPTH + 1);
  localparam int COL_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int ROW_W  = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int CNT_W  = $clog2(MAX_STRINGS + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 1 - LETTER_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STRING_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRING_LENGTH = 2'd1;

  // Main sequencer states
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

### hw/rtl/hamming_radius_one_center_search.sv
// Top level: loads a string set, then searches for a Hamming radius one center string.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets string_count (index 0)
//   and string_length (index 1); 0 acts as 1, values above 16 act as 16. cfg_ready is
//   always high. Write only while the block is idle.
//   s_axis carries one letter code per request, string after string. Letters are
//   taken at one per cycle while loading. The letter that completes
//   string_count * string_length letters starts the search; s_tready is low until the
//   search is done and its results are queued.
//   m_axis returns the center string letter by letter with tlast on its final letter,
//   or a single not-found request (found = 0, letter 0, tlast = 1).
// Search: for each candidate position the whole store is read once, that is up to
//   string_length * string_count * string_length reads at one per cycle through the
//   single read port of the string store; results then leave at one per cycle while
//   the receiver is ready.
// Reset: clears counters and sets both registers to 1; the store needs no clearing.
// A stalled receiver holds the output register and the emit state; once the last result
//   is in it, loading of the next set goes on and its results wait for the register.
module hamming_radius_one_center_search (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hrocs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrocs_pkg::CFG_W-1:0]          cfg_data,
  // Input stream: tdata = letter[4:0], zeros above
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [hrocs_pkg::IN_DATA_W-1:0]      s_tdata,
  // Output stream: tdata = found[0], letter_out[5:1], zeros above
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [hrocs_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  hrocs_pkg::state_t state;

  logic [hrocs_pkg::CFG_W-1:0] string_count;
  logic [hrocs_pkg::CFG_W-1:0] string_length;

  logic [hrocs_pkg::CNT_W-1:0] cnt_eff;
  logic [hrocs_pkg::LEN_W-1:0] len_eff;
  logic [hrocs_pkg::TOT_W-1:0] total;
  logic [hrocs_pkg::COL_W-1:0] len_m1;
  logic [hrocs_pkg::ROW_W-1:0] cnt_m1;

  logic [hrocs_pkg::TOT_W-1:0] load_pos;
  logic [hrocs_pkg::TOT_W-1:0] eff_pos;
  logic [hrocs_pkg::TOT_W-1:0] pos_inc;
  logic                        s_accept;
  logic [hrocs_pkg::LETTER_W-1:0] letter;

  // Copy of the first string, kept in flops
  logic [hrocs_pkg::LETTER_W-1:0] first_str [hrocs_pkg::MAX_LENGTH];
  logic [hrocs_pkg::COL_W-1:0]    first_idx;
  logic [hrocs_pkg::LETTER_W-1:0] first_q;

  // Read issue counters
  logic [hrocs_pkg::LEN_W-1:0]  iss_pos;
  logic [hrocs_pkg::ROW_W-1:0]  iss_k;
  logic [hrocs_pkg::COL_W-1:0]  iss_j;
  logic [hrocs_pkg::ADDR_W-1:0] iss_base;
  logic                         iss_active;
  logic [hrocs_pkg::ADDR_W-1:0] rd_addr;

  // Tags that follow the read data
  logic                         rd_valid;
  logic [hrocs_pkg::COL_W-1:0]  rd_j;
  logic [hrocs_pkg::COL_W-1:0]  rd_pos;
  logic                         rd_lastcol;
  logic                         rd_lastrow;
  logic [hrocs_pkg::LETTER_W-1:0] rd_data;

  // Per-row and per-position evaluation
  logic [1:0]                        mism;
  logic [1:0]                        mism_now;
  logic                              col_miss;
  logic [hrocs_pkg::LETTER_W-1:0]    rowpos;
  logic [hrocs_pkg::LETTER_W-1:0]    rowpos_now;
  logic [hrocs_pkg::LETTER_COUNT-1:0] mask;
  logic [hrocs_pkg::LETTER_COUNT-1:0] allow;
  logic [hrocs_pkg::LETTER_COUNT-1:0] mask_now;
  logic [hrocs_pkg::LETTER_W-1:0]    low_ch;

  // Search result and emit counter
  logic                           found;
  logic [hrocs_pkg::COL_W-1:0]    fpos;
  logic [hrocs_pkg::LETTER_W-1:0] fch;
  logic [hrocs_pkg::COL_W-1:0]    e_j;
  logic [hrocs_pkg::LETTER_W-1:0] emit_letter;
  logic                           out_load;

  // Output register
  logic                           out_found;
  logic [hrocs_pkg::LETTER_W-1:0] out_letter;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == hrocs_pkg::ST_LOAD);
  assign s_accept  = s_tvalid && s_tready;
  assign letter    = s_tdata[hrocs_pkg::LETTER_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      string_count  <= hrocs_pkg::CFG_W'(1);
      string_length <= hrocs_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrocs_pkg::REG_STRING_COUNT:  string_count  <= cfg_data;
        hrocs_pkg::REG_STRING_LENGTH: string_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp registers to the usable range
  always_comb begin
    if (string_count == '0) begin
      cnt_eff = hrocs_pkg::CNT_W'(1);
    end else if (int'(string_count) > hrocs_pkg::MAX_STRINGS) begin
      cnt_eff = hrocs_pkg::CNT_W'(hrocs_pkg::MAX_STRINGS);
    end else begin
      cnt_eff = hrocs_pkg::CNT_W'(string_count);
    end
    if (string_length == '0) begin
      len_eff = hrocs_pkg::LEN_W'(1);
    end else if (int'(string_length) > hrocs_pkg::MAX_LENGTH) begin
      len_eff = hrocs_pkg::LEN_W'(hrocs_pkg::MAX_LENGTH);
    end else begin
      len_eff = hrocs_pkg::LEN_W'(string_length);
    end
  end

  assign total  = hrocs_pkg::TOT_W'(hrocs_pkg::TOT_W'(cnt_eff) * hrocs_pkg::TOT_W'(len_eff));
  assign len_m1 = hrocs_pkg::COL_W'(len_eff - hrocs_pkg::LEN_W'(1));
  assign cnt_m1 = hrocs_pkg::ROW_W'(cnt_eff - hrocs_pkg::CNT_W'(1));

  // Load position, restarting a set if the layout shrank below it
  assign eff_pos = (load_pos >= total) ? '0 : load_pos;
  assign pos_inc = eff_pos + hrocs_pkg::TOT_W'(1);

  // String store
  hrocs_ram #(
    .WIDTH (hrocs_pkg::LETTER_W),
    .DEPTH (hrocs_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (s_accept),
    .wr_addr (eff_pos[hrocs_pkg::ADDR_W-1:0]),
    .wr_data (letter),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // First string mirror
  always_ff @(posedge clk) begin
    if (s_accept && (int'(eff_pos) < hrocs_pkg::MAX_LENGTH)) begin
      first_str[eff_pos[hrocs_pkg::COL_W-1:0]] <= letter;
    end
  end

  assign first_idx = (state == hrocs_pkg::ST_EMIT) ? e_j : rd_j;
  assign first_q   = first_str[first_idx];

  // Read issue
  assign iss_active = (state == hrocs_pkg::ST_SCAN) && (iss_pos < len_eff);
  assign rd_addr    = iss_base + hrocs_pkg::ADDR_W'(iss_j);

  // Evaluate the returning column
  always_comb begin
    col_miss   = (rd_j != rd_pos) && (rd_data != first_q);
    if (mism == 2'd2 || (mism == 2'd1 && col_miss)) begin
      mism_now = 2'd2;
    end else begin
      mism_now = mism + {1'b0, col_miss};
    end
    rowpos_now = (rd_j == rd_pos) ? rd_data : rowpos;
    case (mism_now)
      2'd0:    allow = '1;
      2'd1:    allow = (int'(rowpos_now) < hrocs_pkg::LETTER_COUNT)
                       ? (hrocs_pkg::LETTER_COUNT'(1) << rowpos_now) : '0;
      default: allow = '0;
    endcase
    mask_now = mask & allow;
    // Lowest surviving letter
    low_ch = '0;
    for (int i = hrocs_pkg::LETTER_COUNT - 1; i >= 0; i--) begin
      if (mask_now[i]) begin
        low_ch = hrocs_pkg::LETTER_W'(i);
      end
    end
  end

  assign emit_letter = (e_j == fpos) ? fch : first_q;
  assign out_load    = (state == hrocs_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // Sequencer, counters and search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hrocs_pkg::ST_LOAD;
      load_pos <= '0;
      rd_valid <= 1'b0;
      iss_pos  <= '0;
      iss_k    <= '0;
      iss_j    <= '0;
      iss_base <= '0;
      mism     <= '0;
      mask     <= '1;
      e_j      <= '0;
      found    <= 1'b0;
    end else begin
      rd_valid <= iss_active;
      case (state)
        hrocs_pkg::ST_LOAD: begin
          if (s_accept) begin
            if (pos_inc >= total) begin
              load_pos <= '0;
              state    <= hrocs_pkg::ST_SCAN;
              iss_pos  <= '0;
              iss_k    <= '0;
              iss_j    <= '0;
              iss_base <= '0;
              mism     <= '0;
              mask     <= '1;
            end else begin
              load_pos <= pos_inc;
            end
          end
        end
        hrocs_pkg::ST_SCAN: begin
          // Advance the read walk: column, then row, then position
          if (iss_active) begin
            if (iss_j == len_m1) begin
              iss_j <= '0;
              if (iss_k == cnt_m1) begin
                iss_k    <= '0;
                iss_base <= '0;
                iss_pos  <= iss_pos + hrocs_pkg::LEN_W'(1);
              end else begin
                iss_k    <= iss_k + hrocs_pkg::ROW_W'(1);
                iss_base <= iss_base + hrocs_pkg::ADDR_W'(len_eff);
              end
            end else begin
              iss_j <= iss_j + hrocs_pkg::COL_W'(1);
            end
          end
          // Consume the read data
          if (rd_valid) begin
            if (rd_lastcol) begin
              mism <= '0;
              if (rd_lastrow) begin
                if (mask_now != '0) begin
                  found <= 1'b1;
                  fpos  <= rd_pos;
                  fch   <= low_ch;
                  e_j   <= '0;
                  state <= hrocs_pkg::ST_EMIT;
                end else if (rd_pos == len_m1) begin
                  found <= 1'b0;
                  e_j   <= '0;
                  state <= hrocs_pkg::ST_EMIT;
                end else begin
                  mask <= '1;
                end
              end else begin
                mask <= mask_now;
              end
            end else begin
              mism   <= mism_now;
              rowpos <= rowpos_now;
            end
          end
        end
        hrocs_pkg::ST_EMIT: begin
          if (out_load) begin
            if (!found || e_j == len_m1) begin
              state <= hrocs_pkg::ST_LOAD;
            end else begin
              e_j <= e_j + hrocs_pkg::COL_W'(1);
            end
          end
        end
        default: state <= hrocs_pkg::ST_LOAD;
      endcase
    end
  end

  // Read tags
  always_ff @(posedge clk) begin
    rd_j       <= iss_j;
    rd_pos     <= iss_pos[hrocs_pkg::COL_W-1:0];
    rd_lastcol <= (iss_j == len_m1);
    rd_lastrow <= (iss_k == cnt_m1);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found  <= found;
      out_letter <= found ? emit_letter : '0;
      m_tlast    <= !found || (e_j == len_m1);
    end
  end

  assign m_tdata = {{hrocs_pkg::OUT_PAD_W{1'b0}}, out_letter, out_found};

endmodule

### hw/rtl/hrocs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hrocs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/hrocs_checker.sv
// Port-level checks for the center search block, bound to its top level.
module hrocs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [hrocs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Not-found ends the set
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tlast)
    else $error("not-found result without tlast");

  // Not-found carries a zero letter
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[hrocs_pkg::LETTER_W:1] == '0)
    else $error("not-found result with nonzero letter");

  // A not-found result never follows a found letter within the same set
  a_set_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[0] && !m_tlast ##1 m_tvalid |-> m_tdata[0])
    else $error("found flag changed inside a set");

endmodule

bind hamming_radius_one_center_search hrocs_checker u_hrocs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### tb/sv/testbench.sv
// Testbench for hamming_radius_one_center_search: random string sets checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrocs_pkg::*;

  localparam int RANDOM_LETTERS = 220;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam int MAX_SET_SIZE   = 48;

  // One center letter as it leaves the block
  typedef struct packed {
    bit                found;
    bit [LETTER_W-1:0] code;
    bit                last;
  } center_letter_t;

  // Keeps its own copy of the string store and registers, predicts the center
  // string of every completed set and checks the results in order.
  class center_checker;
    bit [LETTER_W-1:0] store [STORE_DEPTH];
    int unsigned       fill_pos;
    bit [CFG_W-1:0]    count_reg;
    bit [CFG_W-1:0]    length_reg;
    center_letter_t    center_letters[$];
    int                errors;

    function new();
      foreach (store[i]) store[i] = '0;
      fill_pos   = 0;
      count_reg  = 1;
      length_reg = 1;
      errors     = 0;
    endfunction

    // 0 acts as 1, values above the limit act as the limit
    function int unsigned effective(bit [CFG_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, bit [CFG_W-1:0] value);
      if (index == REG_STRING_COUNT) count_reg = value;
      else if (index == REG_STRING_LENGTH) length_reg = value;
    endfunction

    // true if stored string row differs in at most one place from the
    // first string with position pos replaced by ch
    function bit near_row(int unsigned row, int unsigned cols, int unsigned pos,
                          bit [LETTER_W-1:0] ch);
      int unsigned diffs;
      bit [LETTER_W-1:0] want;
      diffs = 0;
      for (int unsigned j = 0; j < cols; j++) begin
        want = (j == pos) ? ch : store[j];
        if (store[row * cols + j] != want) begin
          diffs++;
          if (diffs > 1) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void find_center(int unsigned rows, int unsigned cols);
      bit ok;
      center_letter_t item;
      for (int unsigned pos = 0; pos < cols; pos++) begin
        for (int unsigned ch = 0; ch < LETTER_COUNT; ch++) begin
          ok = 1'b1;
          for (int unsigned k = 0; k < rows && ok; k++)
            ok = near_row(k, cols, pos, LETTER_W'(ch));
          if (ok) begin
            for (int unsigned j = 0; j < cols; j++) begin
              item.found = 1'b1;
              item.code  = (j == pos) ? LETTER_W'(ch) : store[j];
              item.last  = (j + 1 == cols);
              center_letters = {center_letters, item};
            end
            return;
          end
        end
      end
      item.found = 1'b0;
      item.code  = '0;
      item.last  = 1'b1;
      center_letters = {center_letters, item};
    endfunction

    // Accepted letter: store it, search once the set is complete
    function void note_letter(bit [LETTER_W-1:0] code);
      int unsigned rows, cols, total;
      rows  = effective(count_reg, MAX_STRINGS);
      cols  = effective(length_reg, MAX_LENGTH);
      total = rows * cols;
      if (fill_pos >= total) fill_pos = 0;
      store[fill_pos] = code;
      fill_pos++;
      if (fill_pos < total) return;
      fill_pos = 0;
      find_center(rows, cols);
    endfunction

    function void check_result(center_letter_t got);
      center_letter_t want;
      if (center_letters.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual found=%0d letter=%0d last=%0d",
                 $time, got.found, got.code, got.last);
        return;
      end
      want = center_letters.pop_front();
      if (want.found != got.found || want.code != got.code || want.last != got.last) begin
        errors++;
        $display({"%0t: center mismatch: expected found=%0d letter=%0d last=%0d, ",
                  "actual found=%0d letter=%0d last=%0d"},
                 $time, want.found, want.code, want.last, got.found, got.code, got.last);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  center_checker board;
  int unsigned   letters_sent = 0;
  bit            steady_sender = 1'b0;

  hamming_radius_one_center_search DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly letters a..z, sometimes codes above z
  function automatic bit [LETTER_W-1:0] any_code();
    if ($urandom_range(0, 7) == 0) return LETTER_W'($urandom_range(LETTER_COUNT, 31));
    return LETTER_W'($urandom_range(0, LETTER_COUNT - 1));
  endfunction

  function automatic int unsigned gap_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady_sender || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [CFG_W-1:0] pick_register();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return CFG_W'($urandom_range(1, 4));
    if (pick == 7) return '0;
    if (pick == 8) return CFG_W'($urandom_range(5, 16));
    return CFG_W'($urandom_range(17, 31));
  endfunction

  // Write one register; cfg_valid stays high for a following write
  task automatic write_register(logic [CFG_IDX_W-1:0] index, bit [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(index, value);
  endtask

  task automatic write_config(bit [CFG_W-1:0] count, bit [CFG_W-1:0] length);
    write_register(REG_STRING_COUNT, count);
    write_register(REG_STRING_LENGTH, length);
    cfg_valid <= 1'b0;
  endtask

  // One letter request; s_tvalid stays high unless a gap follows
  task automatic send_letter(bit [LETTER_W-1:0] code);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - LETTER_W){1'b0}}, code};
    do @(posedge clk); while (!s_tready);
    board.note_letter(code);
    letters_sent++;
  endtask

  task automatic pause_letters();
    s_tvalid <= 1'b0;
  endtask

  // Block idle: all results in, then a few cycles for any load still in flight
  task automatic settle();
    while (board.center_letters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One full set: either strings near a shared base string or pure noise
  task automatic send_set(int unsigned rows, int unsigned cols, bit structured);
    bit [LETTER_W-1:0] base [MAX_LENGTH];
    int unsigned flip;
    for (int unsigned j = 0; j < cols; j++) base[j] = any_code();
    for (int unsigned r = 0; r < rows; r++) begin
      flip = ($urandom_range(0, 3) != 0) ? $urandom_range(0, cols - 1) : cols;
      for (int unsigned j = 0; j < cols; j++)
        send_letter((!structured || j == flip) ? any_code() : base[j]);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin : watch_results
    center_letter_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.found = m_tdata[0];
      seen.code  = m_tdata[LETTER_W:1];
      seen.last  = m_tlast;
      board.check_result(seen);
    end
  end

  // Receiver: short stalls mostly, some long ones, some long ready stretches
  initial begin : receiver
    int unsigned run, stall, pick;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      pick = $urandom_range(0, 99);
      stall = (pick < 45) ? 0 : (pick < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase, rows, cols, total, start, rest, sets;
    bit [CFG_W-1:0] raw_count, raw_length;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    settle();

    // single letter sets after reset, extremes of the letter code
    send_letter(0);
    send_letter(31);
    pause_letters();
    settle();
    // zero registers act as one
    write_config(0, 0);
    send_letter(LETTER_COUNT - 1);
    pause_letters();
    settle();
    // "ab","cd": center "cb"
    write_config(2, 2);
    send_letter(0); send_letter(1); send_letter(2); send_letter(3);
    pause_letters();
    settle();
    // "ab","cd","ef": no center
    write_config(3, 2);
    send_letter(0); send_letter(1); send_letter(2);
    send_letter(3); send_letter(4); send_letter(5);
    pause_letters();
    settle();
    // layout shrinks below the load position mid-set: next letter restarts
    write_config(2, 3);
    send_letter(7); send_letter(8); send_letter(9);
    pause_letters();
    settle();
    write_config(2, 1);
    send_letter(10); send_letter(11);
    pause_letters();
    settle();
    // layout grows mid-set: loading continues from the kept position
    write_config(2, 2);
    send_letter(12);
    pause_letters();
    settle();
    write_config(3, 2);
    send_letter(12); send_letter(13); send_letter(12); send_letter(14); send_letter(12);
    pause_letters();

    // random phases, extreme layouts first
    start = letters_sent;
    phase = 0;
    while (letters_sent - start < RANDOM_LETTERS) begin
      case (phase)
        0: begin raw_count = 16; raw_length = 1; end
        1: begin raw_count = 1; raw_length = 16; end
        2: begin raw_count = 31; raw_length = 2; end
        3: begin raw_count = 2; raw_length = 31; end
        4: begin raw_count = 0; raw_length = 17; end
        default: begin
          raw_count  = pick_register();
          raw_length = pick_register();
          if (board.effective(raw_count, MAX_STRINGS) * board.effective(raw_length, MAX_LENGTH)
              > MAX_SET_SIZE)
            raw_length = CFG_W'($urandom_range(1, 2));
        end
      endcase
      steady_sender = ($urandom_range(0, 3) == 0);
      settle();
      write_config(raw_count, raw_length);
      rows  = board.effective(raw_count, MAX_STRINGS);
      cols  = board.effective(raw_length, MAX_LENGTH);
      total = rows * cols;
      // complete a set left half loaded under the previous layout
      if (board.fill_pos != 0 && board.fill_pos < total) begin
        rest = total - board.fill_pos;
        repeat (rest) send_letter(any_code());
      end
      sets = (total > 16) ? 1 : $urandom_range(1, 3);
      repeat (sets) send_set(rows, cols, $urandom_range(0, 3) != 0);
      // sometimes leave a set unfinished across the next register write
      if (phase > 4 && total > 1 && $urandom_range(0, 5) == 0) begin
        rest = $urandom_range(1, total - 1);
        repeat (rest) send_letter(any_code());
      end
      pause_letters();
      phase++;
    end

    while (board.center_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("[hamming_radius_one_center_search] OK");
    end else begin
      $display("[hamming_radius_one_center_search] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin : watchdog
    #2_000_000;
    $display("[hamming_radius_one_center_search] ERROR");
    $finish;
  end

endmodule
